[src/dtmf_pkt_pkg.sv]
// Shared types and constants for the DTMF event packetizer.
// Used by the front end, command queue, sequencer and top level. No dependencies.
`default_nettype none

package dtmf_pkt_pkg;

    localparam int CODE_W   = 5;
    localparam int FRAMES_W = 6;
    localparam int IDX_W    = 6;
    localparam int REP_W    = 5;
    localparam int DUR_W    = 16;
    localparam int TS_W     = 11;
    localparam int SPF_W    = 10;
    localparam int RETX_W   = 4;
    localparam int VOL_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL  = 2'd2;

    // configuration reset values
    localparam logic [SPF_W-1:0]  SPF_RESET  = 10'd160;
    localparam logic [RETX_W-1:0] RETX_RESET = 4'd2;
    localparam logic [VOL_W-1:0]  VOL_RESET  = 6'd10;

    // milliseconds per frame, used for timestamps
    localparam int FRAME_MS = 20;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [FRAMES_W-1:0] frames;
    } cmd_t;

    typedef struct packed {
        logic [SPF_W-1:0]  spf;
        logic [RETX_W-1:0] retx;
        logic [VOL_W-1:0]  vol;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic              end_flag;
        logic [VOL_W-1:0]  volume_field;
        logic [DUR_W-1:0]  event_duration;
        logic [TS_W-1:0]   timestamp_offset_ms;
        logic              marker;
        logic              last_packet;
    } pkt_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_END  = 3'b100
    } seq_state_t;

endpackage

`default_nettype wire

[src/dtmf_event_packetizer.sv]
// DTMF event packetizer top level: configuration registers, front end, queue, sequencer.
// Depends on dtmf_pkt_pkg, dtmf_pkt_front, dtmf_pkt_queue, dtmf_pkt_back.
//
// Usage:
//   Input side is a queue: present key_char and duration_ms with push; the
//   transfer happens on a clock edge with push high and full low. An unknown
//   key is taken and dropped without any result.
//   Result side is a queue: while empty is low the oldest packet descriptor is
//   on the result ports; the transfer happens on an edge with pop high.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
//   samples_per_frame (0), retransmit_count (1) or tone_volume (2); other
//   indexes are ignored. cfg_ready is always high. Write only while idle.
// Timing:
//   A key press becomes frames-1 running packets plus retransmit_count+1 end
//   packets, up to 63. A key press passes the queue, which the input transfer
//   edge writes, then the sequencer, once it is idle, and then the output
//   register before its first packet shows on the outputs; then one packet per
//   cycle while pop is held. Up to QUEUE_DEPTH classified key presses wait in the
//   queue; full rises when it fills. A stalled pop holds the output register
//   and the sequencer; nothing is dropped.
// Reset: rst_n clears the queue, the sequencer and the output valid flag, and
//   loads configuration defaults 160, 2, 10.
`default_nettype none

module dtmf_event_packetizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  key_char,
    input  wire logic [15:0] duration_ms,
    // result channel
    output logic             empty,
    input  wire logic        pop,
    output logic [4:0]       event_code,
    output logic             end_flag,
    output logic [5:0]       volume_field,
    output logic [15:0]      event_duration,
    output logic [10:0]      timestamp_offset_ms,
    output logic             marker,
    output logic             last_packet,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

    dtmf_pkt_pkg::cfg_t cfg_reg, cfg_next;
    dtmf_pkt_pkg::cmd_t front_cmd;
    dtmf_pkt_pkg::cmd_t q_cmd;
    dtmf_pkt_pkg::pkt_t out_pkt;
    logic               front_valid;
    logic               q_wr;
    logic               q_valid;
    logic               q_pop;
    logic               out_valid;

    assign cfg_ready = 1'b1;

    // register file: write the selected field, drop unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dtmf_pkt_pkg::CFG_SPF:  cfg_next.spf  = cfg_data;
                dtmf_pkt_pkg::CFG_RETX: cfg_next.retx = cfg_data[3:0];
                dtmf_pkt_pkg::CFG_VOL:  cfg_next.vol  = cfg_data[5:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spf  <= dtmf_pkt_pkg::SPF_RESET;
            cfg_reg.retx <= dtmf_pkt_pkg::RETX_RESET;
            cfg_reg.vol  <= dtmf_pkt_pkg::VOL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify the incoming key press
    dtmf_pkt_front u_front (
        .key_char    (key_char),
        .duration_ms (duration_ms),
        .cmd_valid   (front_valid),
        .cmd         (front_cmd)
    );

    // only recognized keys enter the queue
    assign q_wr = push && !full && front_valid;

    dtmf_pkt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_valid (q_valid),
        .rd_en    (q_pop),
        .rd_cmd   (q_cmd)
    );

    // expand commands into packets
    dtmf_pkt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .pop       (pop),
        .out_valid (out_valid),
        .out_pkt   (out_pkt)
    );

    assign empty               = !out_valid;
    assign event_code          = out_pkt.event_code;
    assign end_flag            = out_pkt.end_flag;
    assign volume_field        = out_pkt.volume_field;
    assign event_duration      = out_pkt.event_duration;
    assign timestamp_offset_ms = out_pkt.timestamp_offset_ms;
    assign marker              = out_pkt.marker;
    assign last_packet         = out_pkt.last_packet;

endmodule

`default_nettype wire

[src/dtmf_pkt_front.sv]
// Front end: maps the key character to an event code and the duration to a frame count.
// Depends on dtmf_pkt_pkg.
`default_nettype none

module dtmf_pkt_front (
    input  wire logic [7:0]           key_char,
    input  wire logic [15:0]          duration_ms,
    output logic                      cmd_valid,
    output dtmf_pkt_pkg::cmd_t        cmd
);

    localparam logic [7:0] KEY_ZERO = 8'h30;
    localparam logic [7:0] KEY_NINE = 8'h39;
    localparam logic [7:0] KEY_STAR = 8'h2A;
    localparam logic [7:0] KEY_HASH = 8'h23;
    localparam logic [7:0] KEY_A    = 8'h41;
    localparam logic [7:0] KEY_B    = 8'h42;
    localparam logic [7:0] KEY_C    = 8'h43;
    localparam logic [7:0] KEY_D    = 8'h44;
    localparam logic [7:0] KEY_F    = 8'h46;

    localparam logic [4:0] EV_STAR = 5'd10;
    localparam logic [4:0] EV_HASH = 5'd11;
    localparam logic [4:0] EV_A    = 5'd12;
    localparam logic [4:0] EV_B    = 5'd13;
    localparam logic [4:0] EV_C    = 5'd14;
    localparam logic [4:0] EV_D    = 5'd15;
    localparam logic [4:0] EV_F    = 5'd16;

    localparam logic [15:0] MIN_MS   = 16'd40;
    localparam logic [15:0] MAX_MS   = 16'd960;
    localparam logic [9:0]  ROUND_MS = 10'd10;
    // (x / 5) for x below 1024 is (x * 205) >> 10
    localparam logic [7:0]  RECIP5   = 8'd205;

    logic [7:0]  key_diff;
    logic [9:0]  dur_clamped;
    logic [9:0]  dur_rounded;
    logic [7:0]  quarter;
    logic [15:0] prod;
    logic [dtmf_pkt_pkg::CODE_W-1:0]   ev_code;
    logic [dtmf_pkt_pkg::FRAMES_W-1:0] frames;

    always_comb
    begin
        key_diff  = key_char - KEY_ZERO;
        cmd_valid = 1'b1;
        ev_code   = '0;
        case (key_char) inside
            [KEY_ZERO:KEY_NINE]: ev_code = key_diff[4:0];
            KEY_STAR:            ev_code = EV_STAR;
            KEY_HASH:            ev_code = EV_HASH;
            KEY_A:               ev_code = EV_A;
            KEY_B:               ev_code = EV_B;
            KEY_C:               ev_code = EV_C;
            KEY_D:               ev_code = EV_D;
            KEY_F:               ev_code = EV_F;
            default:             cmd_valid = 1'b0;
        endcase
    end

    // clamp to 40..960 ms, then frames = (d + 10) / 20 as ((d + 10) / 4) / 5
    always_comb
    begin
        if (duration_ms < MIN_MS)
        begin
            dur_clamped = MIN_MS[9:0];
        end
        else if (duration_ms > MAX_MS)
        begin
            dur_clamped = MAX_MS[9:0];
        end
        else
        begin
            dur_clamped = duration_ms[9:0];
        end
        dur_rounded = dur_clamped + ROUND_MS;
        quarter     = dur_rounded[9:2];
        prod        = {8'd0, quarter} * {8'd0, RECIP5};
        frames      = prod[15:10];
    end

    assign cmd = {ev_code, frames};

endmodule

`default_nettype wire

[src/dtmf_pkt_queue.sv]
// Short command queue between front end and sequencer.
// Depends on dtmf_pkt_pkg.
`default_nettype none

module dtmf_pkt_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire dtmf_pkt_pkg::cmd_t   wr_cmd,
    output logic                      full,
    output logic                      rd_valid,
    input  wire logic                 rd_en,
    output dtmf_pkt_pkg::cmd_t        rd_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dtmf_pkt_pkg::cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

[src/dtmf_pkt_back.sv]
// Sequencer: one queued command to packets, one per cycle unless stalled, in an output register.
// Depends on dtmf_pkt_pkg.
`default_nettype none

module dtmf_pkt_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dtmf_pkt_pkg::cfg_t   cfg,
    input  wire logic                 q_valid,
    input  wire dtmf_pkt_pkg::cmd_t   q_cmd,
    output logic                      q_pop,
    input  wire logic                 pop,
    output logic                      out_valid,
    output dtmf_pkt_pkg::pkt_t        out_pkt
);

    dtmf_pkt_pkg::seq_state_t state_reg, state_next;
    logic [dtmf_pkt_pkg::CODE_W-1:0]   code_reg, code_next;
    logic [dtmf_pkt_pkg::FRAMES_W-1:0] frames_reg, frames_next;
    logic [dtmf_pkt_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [dtmf_pkt_pkg::REP_W-1:0]    rep_reg, rep_next;
    logic [dtmf_pkt_pkg::DUR_W-1:0]    acc_reg, acc_next;
    logic                              out_valid_reg, out_valid_next;
    dtmf_pkt_pkg::pkt_t                pkt_reg, pkt_next;

    logic                              slot_free;
    logic [dtmf_pkt_pkg::IDX_W-1:0]    idx_inc;
    logic [dtmf_pkt_pkg::FRAMES_W-1:0] run_count;
    logic [dtmf_pkt_pkg::TS_W-1:0]     ts;

    assign slot_free = !out_valid_reg || pop;
    assign idx_inc   = idx_reg + 1'b1;
    assign run_count = frames_reg - 1'b1;
    // index * 20 = index * 16 + index * 4
    assign ts = {1'b0, idx_reg, 4'b0} + {3'b0, idx_reg, 2'b0};

    assign out_valid = out_valid_reg;
    assign out_pkt   = pkt_reg;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        frames_next    = frames_reg;
        idx_next       = idx_reg;
        rep_next       = rep_reg;
        acc_next       = acc_reg;
        pkt_next       = pkt_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop          = 1'b0;

        pkt_next.event_code          = code_reg;
        pkt_next.volume_field        = cfg.vol;
        pkt_next.event_duration      = acc_reg;
        pkt_next.timestamp_offset_ms = ts;
        pkt_next.marker              = (idx_reg == '0);
        pkt_next.end_flag            = 1'b0;
        pkt_next.last_packet         = 1'b0;

        case (state_reg)
            dtmf_pkt_pkg::ST_IDLE:
            begin
                pkt_next = pkt_reg;
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    code_next   = q_cmd.code;
                    frames_next = q_cmd.frames;
                    idx_next    = '0;
                    acc_next    = {6'd0, cfg.spf};
                    rep_next    = {1'b0, cfg.retx} + 1'b1;
                    state_next  = dtmf_pkt_pkg::ST_RUN;
                end
            end
            dtmf_pkt_pkg::ST_RUN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    idx_next       = idx_inc;
                    acc_next       = acc_reg + {6'd0, cfg.spf};
                    // advance to end packets once all running packets are out
                    if (idx_inc == run_count)
                    begin
                        state_next = dtmf_pkt_pkg::ST_END;
                    end
                end
                else
                begin
                    pkt_next = pkt_reg;
                end
            end
            dtmf_pkt_pkg::ST_END:
            begin
                pkt_next.end_flag    = 1'b1;
                pkt_next.last_packet = (rep_reg == 5'd1);
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    idx_next       = idx_inc;
                    rep_next       = rep_reg - 1'b1;
                    if (rep_reg == 5'd1)
                    begin
                        state_next = dtmf_pkt_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    pkt_next = pkt_reg;
                end
            end
            default:
            begin
                state_next = dtmf_pkt_pkg::ST_IDLE;
                pkt_next   = pkt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtmf_pkt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            rep_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            rep_reg       <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        frames_reg <= frames_next;
        acc_reg    <= acc_next;
        pkt_reg    <= pkt_next;
    end

    // a new packet appears only while a command is being expanded
    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || pop) && (state_reg == dtmf_pkt_pkg::ST_IDLE) |=> !out_valid_reg)
        else $error("packet emitted from idle sequencer");

    // the end phase always has at least one end packet to send
    a_end_has_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtmf_pkt_pkg::ST_END) |-> (rep_reg != '0))
        else $error("end phase with no repeats left");

    // the closing packet of a command is always an end packet
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pkt_reg.last_packet |-> pkt_reg.end_flag)
        else $error("last packet without end flag");

    // the marker only goes out on the packet stamped at offset zero
    a_marker_ts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pkt_reg.marker |-> (pkt_reg.timestamp_offset_ms == '0))
        else $error("marker on a packet with nonzero timestamp");

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for dtmf_event_packetizer: key presses in, event payload packets out.
// Depends on dtmf_pkt_pkg and the dtmf_event_packetizer RTL; predicts every packet internally.
`default_nettype none

module testbench;

    // register index that the block must ignore
    localparam logic [dtmf_pkt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // event codes for the non-digit keys
    localparam logic [dtmf_pkt_pkg::CODE_W-1:0] EV_STAR = 5'd10;
    localparam logic [dtmf_pkt_pkg::CODE_W-1:0] EV_HASH = 5'd11;
    localparam logic [dtmf_pkt_pkg::CODE_W-1:0] EV_A    = 5'd12;
    localparam logic [dtmf_pkt_pkg::CODE_W-1:0] EV_B    = 5'd13;
    localparam logic [dtmf_pkt_pkg::CODE_W-1:0] EV_C    = 5'd14;
    localparam logic [dtmf_pkt_pkg::CODE_W-1:0] EV_D    = 5'd15;
    localparam logic [dtmf_pkt_pkg::CODE_W-1:0] EV_F    = 5'd16;

    // duration clamp bounds
    localparam int MIN_TONE_MS = 40;
    localparam int MAX_TONE_MS = 960;

    // cycles to let pass once the last packet is out: queue, sequencer, output register
    localparam int DRAIN_CYCLES = 12;
    // worst case is far below this: 63 packets per key, each waiting a long stall
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int MAX_REPORTS  = 10;
    localparam int ITEMS_PER_PHASE = 25;

    // ring of predicted packets; far deeper than the most ever outstanding
    localparam int EXP_DEPTH = 4096;
    localparam int EXP_PTR_W = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        push = 1'b0;
    logic        full;
    logic [7:0]  key_char = 8'd0;
    logic [15:0] duration_ms = 16'd0;

    logic        empty;
    logic        pop = 1'b0;
    logic [4:0]  event_code;
    logic        end_flag;
    logic [5:0]  volume_field;
    logic [15:0] event_duration;
    logic [10:0] timestamp_offset_ms;
    logic        marker;
    logic        last_packet;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [9:0]  cfg_data = 10'd0;

    // shadow copy of the configuration registers
    logic [dtmf_pkt_pkg::SPF_W-1:0]  shadow_spf  = dtmf_pkt_pkg::SPF_RESET;
    logic [dtmf_pkt_pkg::RETX_W-1:0] shadow_retx = dtmf_pkt_pkg::RETX_RESET;
    logic [dtmf_pkt_pkg::VOL_W-1:0]  shadow_vol  = dtmf_pkt_pkg::VOL_RESET;

    // packets predicted but not yet seen on the result side
    dtmf_pkt_pkg::pkt_t exp_mem [EXP_DEPTH];
    int unsigned exp_wr_total = 0;
    int unsigned exp_rd_total = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    // result-side pacing; hold_req asks the drain process for a long hold-off
    int unsigned hold_req  = 0;
    int unsigned hold_left = 0;
    int unsigned span_left = 0;
    bit          pop_on    = 1'b0;

    string key_set = "0123456789*#ABCDF";

    dtmf_event_packetizer i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .key_char            (key_char),
        .duration_ms         (duration_ms),
        .empty               (empty),
        .pop                 (pop),
        .event_code          (event_code),
        .end_flag            (end_flag),
        .volume_field        (volume_field),
        .event_duration      (event_duration),
        .timestamp_offset_ms (timestamp_offset_ms),
        .marker              (marker),
        .last_packet         (last_packet),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always #5 clk = ~clk;

    // Number of predicted packets still to come.
    function automatic int unsigned pending_count();
        return exp_wr_total - exp_rd_total;
    endfunction

    // Append one predicted packet to the ring.
    function automatic void expect_packet(input dtmf_pkt_pkg::pkt_t p);
        exp_mem[EXP_PTR_W'(exp_wr_total)] = p;
        exp_wr_total++;
    endfunction

    // Take the oldest predicted packet from the ring.
    function automatic dtmf_pkt_pkg::pkt_t next_expected();
        dtmf_pkt_pkg::pkt_t p;
        p = exp_mem[EXP_PTR_W'(exp_rd_total)];
        exp_rd_total++;
        return p;
    endfunction

    // Gap length for either side: mostly none, often short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Mostly valid keys; the rest any byte, so every key bit toggles.
    function automatic logic [7:0] pick_key();
        if ($urandom_range(0, 99) < 75)
            return key_set[$urandom_range(0, 16)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Favor short tones; still hit the clamp edges and the whole 16-bit range.
    function automatic logic [15:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 16'($urandom_range(0, 120));
        if (r < 65)
            return 16'($urandom_range(0, 1000));
        if (r < 75)
            return 16'($urandom_range(930, 1000));
        if (r < 90)
            return 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'(MIN_TONE_MS - 1);
            3: return 16'(MAX_TONE_MS + 1);
            4: return 16'd49;
            default: return 16'd50;
        endcase
    endfunction

    // Expand one accepted key press into its packets under the current registers.
    function automatic void packetize_key(input logic [7:0] key, input logic [15:0] dur_in);
        logic [dtmf_pkt_pkg::CODE_W-1:0] code;
        bit   known;
        int   d;
        int   frames;
        int   total;
        int   n;
        dtmf_pkt_pkg::pkt_t p;
        known = 1'b1;
        code  = '0;
        if (key >= "0" && key <= "9")
            code = dtmf_pkt_pkg::CODE_W'(key - "0");
        else
        begin
            case (key)
                "*": code = EV_STAR;
                "#": code = EV_HASH;
                "A": code = EV_A;
                "B": code = EV_B;
                "C": code = EV_C;
                "D": code = EV_D;
                "F": code = EV_F;
                default: known = 1'b0;
            endcase
        end
        if (!known)
            return;
        d = dur_in;
        if (d < MIN_TONE_MS)
            d = MIN_TONE_MS;
        if (d > MAX_TONE_MS)
            d = MAX_TONE_MS;
        frames = (d + 10) / dtmf_pkt_pkg::FRAME_MS;
        // frames-1 running packets, then retransmit_count+1 end packets
        total = frames - 1 + int'(shadow_retx) + 1;
        for (n = 0; n < total; n++)
        begin
            p.event_code          = code;
            p.end_flag            = (n >= frames - 1);
            p.volume_field        = shadow_vol;
            p.event_duration      = p.end_flag
                ? dtmf_pkt_pkg::DUR_W'(frames * int'(shadow_spf))
                : dtmf_pkt_pkg::DUR_W'((n + 1) * int'(shadow_spf));
            p.timestamp_offset_ms = dtmf_pkt_pkg::TS_W'(n * dtmf_pkt_pkg::FRAME_MS);
            p.marker              = (n == 0);
            p.last_packet         = (n == total - 1);
            expect_packet(p);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
                         name, want, got, cycle_count);
        end
    endfunction

    // Compare every result transfer against the oldest predicted packet.
    always @(posedge clk)
    begin : result_check
        dtmf_pkt_pkg::pkt_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_count() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected packet: code %0d dur %0d ts %0d (cycle %0d)",
                             event_code, event_duration, timestamp_offset_ms, cycle_count);
            end
            else
            begin
                want = next_expected();
                check_field("event_code", 32'(want.event_code), 32'(event_code));
                check_field("end_flag", 32'(want.end_flag), 32'(end_flag));
                check_field("volume_field", 32'(want.volume_field), 32'(volume_field));
                check_field("event_duration", 32'(want.event_duration),
                            32'(event_duration));
                check_field("timestamp_offset_ms", 32'(want.timestamp_offset_ms),
                            32'(timestamp_offset_ms));
                check_field("marker", 32'(want.marker), 32'(marker));
                check_field("last_packet", 32'(want.last_packet), 32'(last_packet));
            end
        end
    end

    // Pace pop: random runs and stalls, plus a counted hold-off on request.
    always @(posedge clk)
    begin : result_drain
        if (rst_n)
        begin
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                // hold pop low; restart with a fresh run once the count is out
                hold_left--;
                span_left = 0;
                pop_on    = 1'b0;
                pop <= 1'b0;
            end
            else if (span_left != 0)
            begin
                span_left--;
            end
            else
            begin
                if (pop_on)
                begin
                    span_left = pick_gap();
                    pop_on    = (span_left == 0);
                end
                else
                    pop_on = 1'b1;
                if (pop_on)
                    span_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                           : $urandom_range(1, 20);
                pop <= pop_on;
            end
        end
    end

    // Offer one key press; advance until the transfer, then maybe drop push for a gap.
    task automatic send_key(input logic [7:0] key, input logic [15:0] dur);
        int unsigned gap;
        push        <= 1'b1;
        key_char    <= key;
        duration_ms <= dur;
        @(posedge clk);
        while (full)
            @(posedge clk);
        packetize_key(key, dur);
        gap = pick_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write one register and mirror it in the shadow copy.
    task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            dtmf_pkt_pkg::CFG_SPF:  shadow_spf  = data[dtmf_pkt_pkg::SPF_W-1:0];
            dtmf_pkt_pkg::CFG_RETX: shadow_retx = data[dtmf_pkt_pkg::RETX_W-1:0];
            dtmf_pkt_pkg::CFG_VOL:  shadow_vol  = data[dtmf_pkt_pkg::VOL_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering, wait for every predicted packet, then let the pipeline settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers, upper data bits random where the register is narrower,
    // and poke the unused index to show it changes nothing.
    task automatic load_settings(input int unsigned spf, input int unsigned retx,
                                 input int unsigned vol);
        write_reg(dtmf_pkt_pkg::CFG_SPF, 10'(spf));
        write_reg(dtmf_pkt_pkg::CFG_RETX, {6'($urandom_range(0, 63)), 4'(retx)});
        write_reg(dtmf_pkt_pkg::CFG_VOL, {4'($urandom_range(0, 15)), 6'(vol)});
        write_reg(CFG_UNUSED, 10'($urandom_range(0, 1023)));
    endtask

    // Every key at reset settings, with the clamp and rounding edges and unknown keys.
    task automatic test_key_map();
        logic [7:0]  keys [21];
        logic [15:0] durs [21];
        int i;
        keys = '{"0", "1", "2", "3", "4", "5", "6", "7", "8", "9", "*", "#",
                 "A", "B", "C", "D", "F", 8'h00, 8'hFF, "E", "a"};
        durs = '{16'd0, 16'hFFFF, 16'd39, 16'd40, 16'd41, 16'd49, 16'd50, 16'd69,
                 16'd70, 16'd959, 16'd960, 16'd961, 16'd1000, 16'd20, 16'd100,
                 16'd500, 16'd45, 16'd80, 16'd300, 16'd60, 16'hFFFF};
        for (i = 0; i < 21; i++)
            send_key(keys[i], durs[i]);
        wait_drained();
    endtask

    // Sender pauses until every packet is out, then resumes.
    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 4; i++)
            send_key(key_set[$urandom_range(0, 16)], pick_duration());
        wait_drained();
        for (i = 0; i < 4; i++)
            send_key(pick_key(), pick_duration());
        wait_drained();
    endtask

    // Random traffic across several register settings, extremes included.
    task automatic test_random_traffic();
        int ph;
        int i;
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_settings(dtmf_pkt_pkg::SPF_RESET, dtmf_pkt_pkg::RETX_RESET,
                                 dtmf_pkt_pkg::VOL_RESET);
                1: load_settings(20, 0, 0);
                2: load_settings(960, 15, 63);
                3: load_settings(1023, 15, 63);
                4: load_settings(0, 0, 63);
                5: load_settings($urandom_range(1, 19), 7, 1);
                default: load_settings($urandom_range(0, 1023), $urandom_range(0, 15),
                                       $urandom_range(0, 63));
            endcase
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                send_key(pick_key(), pick_duration());
            wait_drained();
        end
    endtask

    // Hold the result side off while long tones keep coming, so full must rise.
    task automatic test_backpressure();
        int i;
        load_settings(480, 15, 33);
        hold_req = 400;
        for (i = 0; i < 10; i++)
            send_key(key_set[$urandom_range(0, 16)], 16'($urandom_range(900, 2000)));
        wait_drained();
    endtask

    // Watchdog: end the run if it never drains.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        // hold reset low, then release it on an edge
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_key_map();
        test_drain_pause();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        if (err_count == 0 && pending_count() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
